>>> hdl/rnxarb_pkg.sv
`default_nettype none

package rnxarb_pkg;

  // Fixed field widths of the two channels and the configuration register.
  localparam int ID_W       = 4;
  localparam int RING_CFG_W = 5;

  // Ring size taken at reset, before clamping to the ring capacity.
  localparam int RING_SIZE_RESET = 16;

  // Command codes on the input channel.
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Block bits kept for each client.
  localparam logic [1:0] BLOCK_NEXT = 2'b01;
  localparam logic [1:0] BLOCK_PREV = 2'b10;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] client_id;
  } rnxarb_in_t;

  typedef struct packed {
    logic [ID_W-1:0] grant_id;
    logic            last;
  } rnxarb_out_t;

endpackage

`default_nettype wire

>>> hdl/rnxarb_qcell.sv
`default_nettype none

module rnxarb_qcell
  import rnxarb_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire logic            load_en,
  input  wire logic [ID_W-1:0] load_id,
  input  wire logic [ID_W-1:0] up_id,
  output logic      [ID_W-1:0] id_q
);

  logic [ID_W-1:0] id_r;

  // A load wins over the shift, so the entry that is written back at the
  // tail of the scan is not overwritten by its upstream neighbor.
  always_ff @(posedge clk) begin
    if (load_en) begin
      id_r <= load_id;
    end else if (shift_en) begin
      id_r <= up_id;
    end
  end

  assign id_q = id_r;

endmodule

`default_nettype wire

>>> hdl/ring_neighbour_exclusion_arbiter_core.sv
// Channel   Ports                            Handshake
// input     start, busy, in_data             beat taken when start is high and busy is low
// result    out_strobe, out_data             beat valid for one cycle, always taken
// config    cfg_we, cfg_wdata                ring size written when cfg_we is high
//
// After its accept cycle an item is scanned: the row of queue cells shifts each entry
// of the queue, as it stands after the item, past the grant check in turn, and a
// closing step ends the scan and returns to idle.
// An item whose id lies outside the ring is dropped at accept and leaves busy low.
// Reset is synchronous and active low; the ring size returns to 16, clamped to MAX_CLIENTS.
// The receiver cannot stall, so grants leave as fast as the scan makes them.
`default_nettype none

module ring_neighbour_exclusion_arbiter_core
  import rnxarb_pkg::*;
#(
  parameter int MAX_CLIENTS = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire rnxarb_in_t            in_data,
  output logic                       out_strobe,
  output rnxarb_out_t                out_data,
  input  wire logic                  cfg_we,
  input  wire logic [RING_CFG_W-1:0] cfg_wdata
);

  // Width of a client index, of the ring size and of a common compare.
  localparam int IDX_W  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int RS_W   = $clog2(MAX_CLIENTS + 1);
  localparam int CMP_W  = ((RS_W > ID_W) ? RS_W : ID_W) + 1;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RING_RST = (RING_SIZE_RESET > MAX_CLIENTS) ? MAX_CLIENTS
                                                            : RING_SIZE_RESET;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef logic [1:0] blk_t;

  state_t              state_r, state_nxt;
  logic [RS_W-1:0]     ring_r, ring_nxt;
  blk_t                blk_r   [MAX_CLIENTS];
  blk_t                blk_nxt [MAX_CLIENTS];
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [QCNT_W-1:0]   len_r, len_nxt;
  logic [QCNT_W-1:0]   rd_r, rd_nxt;
  logic [QCNT_W-1:0]   wr_r, wr_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic                strobe_r, strobe_nxt;
  rnxarb_out_t         out_r, out_nxt;

  logic [ID_W-1:0]     cell_q   [QUEUE_DEPTH];
  logic [ID_W-1:0]     cell_up  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ld;
  logic [ID_W-1:0]     cell_ld_id;
  logic                cell_shift;

  logic                accept;
  logic                in_range;
  logic [IDX_W-1:0]    in_idx;
  logic [ID_W-1:0]     head_id;
  logic [IDX_W-1:0]    head_idx;
  logic                head_stale;
  logic                head_grant;
  logic                scan_step;
  logic [QCNT_W-1:0]   tail_pos;

  function automatic logic [RS_W-1:0] clamp_ring(input logic [RING_CFG_W-1:0] v);
    logic [RS_W-1:0] res;
    if (v == '0) begin
      res = RS_W'(1);
    end else if (int'(v) > MAX_CLIENTS) begin
      res = RS_W'(MAX_CLIENTS);
    end else begin
      res = RS_W'(v);
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] prev_of(input logic [IDX_W-1:0] id,
                                               input logic [RS_W-1:0] ring);
    logic [IDX_W-1:0] res;
    if (id == '0) begin
      res = IDX_W'(ring - RS_W'(1));
    end else begin
      res = id - IDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] next_of(input logic [IDX_W-1:0] id,
                                               input logic [RS_W-1:0] ring);
    logic [IDX_W-1:0] res;
    if ((CMP_W'(id) + CMP_W'(1)) >= CMP_W'(ring)) begin
      res = '0;
    end else begin
      res = id + IDX_W'(1);
    end
    return res;
  endfunction

  // The wait queue is a row of cells with the oldest entry in cell 0. During
  // the scan every cell takes its upstream neighbor's entry each cycle, so the
  // head entry reaches the grant check one per cycle. An entry that stays
  // blocked is written back behind the entries still to be scanned, which
  // leaves the survivors packed from cell 0 in their old order at the end.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_up[gi] = '0;
    end else begin : g_mid
      assign cell_up[gi] = cell_q[gi+1];
    end

    rnxarb_qcell u_cell (
      .clk      (clk),
      .shift_en (cell_shift),
      .load_en  (cell_ld[gi]),
      .load_id  (cell_ld_id),
      .up_id    (cell_up[gi]),
      .id_q     (cell_q[gi])
    );
  end

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = CMP_W'(in_data.client_id) < CMP_W'(ring_r);
  assign in_idx   = IDX_W'(in_data.client_id);

  assign head_id    = cell_q[0];
  assign head_idx   = IDX_W'(head_id);
  assign head_stale = CMP_W'(head_id) >= CMP_W'(ring_r);
  assign scan_step  = (state_r == S_SCAN) && (rd_r != len_r);
  assign head_grant = scan_step && !head_stale && (blk_r[head_idx] == '0);

  // Slot behind the entries not yet scanned and the survivors already kept.
  assign tail_pos = len_r - QCNT_W'(1) - rd_r + wr_r;

  assign cell_shift = scan_step;
  assign cell_ld_id = scan_step ? head_id : in_data.client_id;

  always_comb begin
    cell_ld = '0;
    if (accept && in_range && (in_data.cmd == CMD_REQUEST) &&
        (cnt_r < QCNT_W'(QUEUE_DEPTH))) begin
      cell_ld[QIDX_W'(cnt_r)] = 1'b1;
    end else if (scan_step && !head_stale && !head_grant) begin
      cell_ld[QIDX_W'(tail_pos)] = 1'b1;
    end
  end

  // Block bit table: a ring size write clears every bit; a release clears the
  // bits the releaser put on its neighbors; a grant clears the grantee's own bits and
  // then marks both neighbors, so on a ring of one the marks survive on the client itself.
  always_comb begin
    logic [IDX_W-1:0] p_idx;
    logic [IDX_W-1:0] n_idx;
    p_idx = '0;
    n_idx = '0;
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      blk_nxt[i] = blk_r[i];
    end
    if (cfg_we) begin
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        blk_nxt[i] = '0;
      end
    end else if (accept && in_range && (in_data.cmd == CMD_RELEASE)) begin
      p_idx = prev_of(in_idx, ring_r);
      n_idx = next_of(in_idx, ring_r);
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        if (IDX_W'(i) == p_idx) begin
          blk_nxt[i] = blk_nxt[i] & ~BLOCK_NEXT;
        end
        if (IDX_W'(i) == n_idx) begin
          blk_nxt[i] = blk_nxt[i] & ~BLOCK_PREV;
        end
      end
    end else if (head_grant) begin
      p_idx = prev_of(head_idx, ring_r);
      n_idx = next_of(head_idx, ring_r);
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        if (IDX_W'(i) == head_idx) begin
          blk_nxt[i] = '0;
        end
        if (IDX_W'(i) == p_idx) begin
          blk_nxt[i] = blk_nxt[i] | BLOCK_NEXT;
        end
        if (IDX_W'(i) == n_idx) begin
          blk_nxt[i] = blk_nxt[i] | BLOCK_PREV;
        end
      end
    end
  end

  // Scan control. A grant is held back in the pending register until the next grant
  // or the end of the scan, because only the end of the scan tells whether it is the last one.
  always_comb begin
    state_nxt    = state_r;
    ring_nxt     = cfg_we ? clamp_ring(cfg_wdata) : ring_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    strobe_nxt   = 1'b0;
    out_nxt      = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_range) begin
          if ((in_data.cmd == CMD_REQUEST) && (cnt_r < QCNT_W'(QUEUE_DEPTH))) begin
            len_nxt = cnt_r + QCNT_W'(1);
          end else begin
            len_nxt = cnt_r;
          end
          cnt_nxt      = len_nxt;
          rd_nxt       = '0;
          wr_nxt       = '0;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_r == len_r) begin
          cnt_nxt = wr_r;
          if (pend_vld_r) begin
            strobe_nxt       = 1'b1;
            out_nxt.grant_id = pend_id_r;
            out_nxt.last     = 1'b1;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          rd_nxt = rd_r + QCNT_W'(1);
          if (head_grant) begin
            if (pend_vld_r) begin
              strobe_nxt       = 1'b1;
              out_nxt.grant_id = pend_id_r;
              out_nxt.last     = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = head_id;
          end else if (!head_stale) begin
            wr_nxt = wr_r + QCNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ring_r     <= RS_W'(RING_RST);
      cnt_r      <= '0;
      len_r      <= '0;
      rd_r       <= '0;
      wr_r       <= '0;
      pend_vld_r <= 1'b0;
      pend_id_r  <= '0;
      strobe_r   <= 1'b0;
      out_r      <= '0;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        blk_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      ring_r     <= ring_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      rd_r       <= rd_nxt;
      wr_r       <= wr_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_id_r  <= pend_id_nxt;
      strobe_r   <= strobe_nxt;
      out_r      <= out_nxt;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        blk_r[i] <= blk_nxt[i];
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

>>> bench/ring_neighbour_exclusion_arbiter_tb.sv
`timescale 1ns / 1ps

import rnxarb_pkg::*;

localparam int SEATS = 16;
localparam int DEPTH = 16;

// Tracks the ring, the block bits and the wait queue, and predicts the grants.
class grant_ledger;
  int unsigned     ring;
  bit [1:0]        blocks[SEATS];
  bit              held[SEATS];
  logic [ID_W-1:0] waiters[$];
  rnxarb_out_t     due_grants[$];
  int unsigned     errors;

  function new();
    ring = seats_for(RING_CFG_W'(RING_SIZE_RESET));
    errors = 0;
    foreach (blocks[i]) begin
      blocks[i] = 2'b00;
      held[i] = 1'b0;
    end
  endfunction

  function int unsigned seats_for(logic [RING_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SEATS) return SEATS;
    return v;
  endfunction

  function int unsigned prev_seat(int unsigned id, int unsigned rs);
    return (id == 0) ? rs - 1 : id - 1;
  endfunction

  function int unsigned next_seat(int unsigned id, int unsigned rs);
    return (id + 1 >= rs) ? 0 : id + 1;
  endfunction

  // A new ring size drops every block bit; queued entries stay.
  function void set_ring(logic [RING_CFG_W-1:0] v);
    ring = seats_for(v);
    foreach (blocks[i]) begin
      blocks[i] = 2'b00;
      held[i] = 1'b0;
    end
  endfunction

  function void scan_waiters();
    logic [ID_W-1:0] kept[$];
    logic [ID_W-1:0] won[$];
    rnxarb_out_t     g;
    foreach (waiters[r]) begin
      // Entries left over from a larger ring vanish without a grant.
      if (waiters[r] >= ring) continue;
      if (blocks[waiters[r]] == 2'b00) begin
        blocks[prev_seat(waiters[r], ring)] |= BLOCK_NEXT;
        blocks[next_seat(waiters[r], ring)] |= BLOCK_PREV;
        held[waiters[r]] = 1'b1;
        won = {won, waiters[r]};
      end else begin
        kept = {kept, waiters[r]};
      end
    end
    waiters = kept;
    foreach (won[k]) begin
      g.grant_id = won[k];
      g.last = (k == won.size() - 1);
      due_grants = {due_grants, g};
    end
  endfunction

  function void accept_beat(rnxarb_in_t b);
    int unsigned id;
    id = b.client_id;
    if (id >= ring) return;
    if (b.cmd == CMD_REQUEST) begin
      if (waiters.size() < DEPTH) waiters = {waiters, b.client_id};
    end else begin
      blocks[prev_seat(id, ring)] &= ~BLOCK_NEXT;
      blocks[next_seat(id, ring)] &= ~BLOCK_PREV;
      held[id] = 1'b0;
    end
    scan_waiters();
  endfunction

  function void check_grant(rnxarb_out_t got);
    rnxarb_out_t want;
    if (due_grants.size() == 0) begin
      $error("unexpected grant: grant_id %0d last %0b", got.grant_id, got.last);
      errors++;
      return;
    end
    want = due_grants.pop_front();
    if (got.grant_id !== want.grant_id) begin
      $error("grant_id: expected %0d, got %0d", want.grant_id, got.grant_id);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return due_grants.size();
  endfunction

  function void close_out();
    if (due_grants.size() != 0) begin
      $error("%0d grants never arrived", due_grants.size());
      errors++;
    end
  endfunction
endclass

module tb;

  // This many quiet cycles outlast any scan still under way, even with a full queue.
  localparam int SETTLE = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  rnxarb_in_t            in_data;
  logic                  out_strobe;
  rnxarb_out_t           out_data;
  logic                  cfg_we;
  logic [RING_CFG_W-1:0] cfg_wdata;

  grant_ledger book;
  // Idle bursts follow a beat with odds of one in gap_odds; zero means none.
  int unsigned gap_odds;

  ring_neighbour_exclusion_arbiter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Everything is sampled at the rising edge, before the block's registers
  // move, so a beat is seen exactly as the block takes it. Grants seen at an
  // edge always belong to older beats than one taken at that same edge, so
  // the order of these three calls does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) book.set_ring(cfg_wdata);
      if (start && !busy) book.accept_beat(in_data);
      if (out_strobe) book.check_grant(out_data);
    end
  end

  // Offers one beat and returns at the edge that takes it, or after the idle burst that
  // may follow it. The start line is left high so that a following beat can go out back to back; an idle
  // burst, a settle or the end of the run lowers it.
  task automatic send_beat(input int unsigned cmd, input int unsigned id);
    rnxarb_in_t b;
    b.cmd = cmd[0];
    b.client_id = id[ID_W-1:0];
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      // Junk on the data lines while start is low must be ignored.
      b.cmd = 1'($urandom_range(0, 1));
      b.client_id = ID_W'($urandom_range(0, SEATS - 1));
      start <= 1'b0;
      in_data <= b;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // The ring size may only change once every grant has come out and the
  // scan that follows a grantless beat has had time to finish.
  task automatic write_ring(input logic [RING_CFG_W-1:0] v);
    start <= 1'b0;
    while (book.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_part();
    gap_odds = 3;
    // Full ring of sixteen at reset: grants, blocked neighbors, duplicates.
    send_beat(CMD_REQUEST, 0);
    send_beat(CMD_REQUEST, 1);
    send_beat(CMD_REQUEST, 15);
    send_beat(CMD_REQUEST, 2);
    send_beat(CMD_REQUEST, 2);
    send_beat(CMD_RELEASE, 0);
    send_beat(CMD_RELEASE, 2);
    send_beat(CMD_RELEASE, 7);
    send_beat(CMD_REQUEST, 3);
    send_beat(CMD_RELEASE, 15);
    send_beat(CMD_RELEASE, 1);
    send_beat(CMD_RELEASE, 3);
    // Leave two blocked entries that a smaller ring will find stale.
    send_beat(CMD_REQUEST, 8);
    send_beat(CMD_REQUEST, 9);
    send_beat(CMD_REQUEST, 7);
    write_ring(5'd17);
    // A ring size of zero means a ring of one, where a client neighbors
    // itself; ids beyond the ring are ignored.
    write_ring(5'd0);
    send_beat(CMD_REQUEST, 0);
    send_beat(CMD_REQUEST, 0);
    send_beat(CMD_REQUEST, 5);
    send_beat(CMD_RELEASE, 15);
    send_beat(CMD_RELEASE, 0);
    send_beat(CMD_RELEASE, 0);
    // Ring of two: both neighbors of a client are the same client.
    write_ring(5'd2);
    send_beat(CMD_REQUEST, 1);
    send_beat(CMD_REQUEST, 0);
    send_beat(CMD_RELEASE, 1);
    send_beat(CMD_RELEASE, 0);
  endtask

  // Mostly requests and releases of real holders, with floods that pile the
  // neighbors of one holder into the queue, at times until it overflows, and some
  // noise with ids that may lie outside the ring.
  task automatic random_phase(input logic [RING_CFG_W-1:0] v, input int unsigned quota,
                              input bit quiet);
    int unsigned rs;
    int unsigned sent;
    int unsigned pick;
    int unsigned h;
    int unsigned n;
    int unsigned k;
    int unsigned id;
    write_ring(v);
    gap_odds = quiet ? 0 : 2 * $urandom_range(0, 3);
    rs = book.seats_for(v);
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_beat(CMD_REQUEST, $urandom_range(0, rs - 1));
        sent++;
      end else if (pick < 75) begin
        // Release the first holder found from a random seat, or anyone.
        h = $urandom_range(0, rs - 1);
        for (k = 0; k < rs && !book.held[(h + k) % rs]; k++) ;
        send_beat(CMD_RELEASE, (h + k) % rs);
        sent++;
      end else if (pick < 85) begin
        h = $urandom_range(0, rs - 1);
        n = $urandom_range(12, 22);
        send_beat(CMD_REQUEST, h);
        repeat (n) begin
          send_beat(CMD_REQUEST, $urandom_range(0, 1) ? book.prev_seat(h, rs)
                                                      : book.next_seat(h, rs));
        end
        send_beat(CMD_RELEASE, h);
        sent += n + 2;
      end else begin
        id = $urandom_range(0, SEATS - 1);
        send_beat($urandom_range(0, 1), id);
        if (id < rs) sent++;
      end
    end
  endtask

  initial begin
    int unsigned k;
    book = new();
    gap_odds = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    random_phase(5'd0, 8, 1'b0);
    random_phase(5'd2, 10, 1'b0);
    random_phase(5'd31, 12, 1'b0);
    random_phase(5'd3, 10, 1'b0);
    random_phase(5'($urandom_range(4, 15)), 12, 1'b0);
    random_phase(5'd1, 8, 1'b0);
    random_phase(5'd17, 12, 1'b0);
    // The closing stretch runs back to back with no idling.
    random_phase(5'd16, 14, 1'b1);

    start <= 1'b0;
    for (k = 0; k < 4000 && book.pending() != 0; k++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    book.close_out();
    if (book.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // A hung handshake ends here.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
